// ----- rtl/vpw_pulse_width_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// VPW decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VPW_PULSE_WIDTH_DECODER_MACROS_SVH
`define VPW_PULSE_WIDTH_DECODER_MACROS_SVH

// same-cycle implication
`define VPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vpw_pkg.sv -----
// ----------------------------------------------------------------------------
// VPW decoder package
// Register indexes, reset values, ASCII codes and the millisecond digit split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpw_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned MS_W      = 10;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned MAX_CHARS = 6;
    localparam int unsigned CNT_W     = 3;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;
    typedef logic [CNT_W-1:0]  char_cnt_t;

    localparam reg_idx_t REG_SHORT_MIN   = 3'd0;
    localparam reg_idx_t REG_LONG_MIN    = 3'd1;
    localparam reg_idx_t REG_SOF_MIN     = 3'd2;
    localparam reg_idx_t REG_EOF_MIN     = 3'd3;
    localparam reg_idx_t REG_START_LEVEL = 3'd4;

    localparam tick_t SHORT_MIN_RST   = 16'd52;
    localparam tick_t LONG_MIN_RST    = 16'd145;
    localparam tick_t SOF_MIN_RST     = 16'd246;
    localparam tick_t EOF_MIN_RST     = 16'd360;
    localparam logic  START_LEVEL_RST = 1'b0;

    localparam char_t CHAR_CR     = 8'h0D;
    localparam char_t CHAR_LF     = 8'h0A;
    localparam char_t CHAR_J      = 8'h4A;
    localparam char_t CHAR_ZERO   = 8'h30;
    localparam char_t CHAR_HEX_AF = 8'h37;

    localparam char_cnt_t CNT_NONE  = 3'd0;
    localparam char_cnt_t CNT_ONE   = 3'd1;
    localparam char_cnt_t CNT_EOL   = 3'd2;
    localparam char_cnt_t CNT_FRAME = 3'd6;

    typedef struct packed {
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } digits_t;

    // decimal split by parallel compares, input saturated at 999
    function automatic digits_t ms_digits(input logic [MS_W-1:0] ms);
        logic [MS_W-1:0] v;
        logic [3:0]      h;
        logic [3:0]      t;
        logic [6:0]      r;
        digits_t         d;
        v = (ms > 10'd999) ? 10'd999 : ms;
        h = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 10'(k * 100))
                h = 4'(k);
        end
        r = 7'(v - 10'(h) * 10'd100);
        t = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (r >= 7'(k * 10))
                t = 4'(k);
        end
        d.hun = h;
        d.ten = t;
        d.one = 4'(r - 7'(t) * 7'd10);
        return d;
    endfunction

endpackage

// ----- rtl/vpw_pulse_width_decoder.sv -----
// Pipeline: an item is registered, then decoded into a character buffer, and its first
// character is offered from that buffer.
// Throughput: one item per cycle while no characters are pending; an item with
// characters holds the next item until the single output character port takes its last one.
// Reset: asynchronous, active low; control registers take their defaults, data registers do not; no clearing pass.
// ----------------------------------------------------------------------------
// VPW pulse width decoder
// Turns edge and timeout events into a text stream of frame headers, hex nibbles and line ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpw_pulse_width_decoder #(
    parameter int unsigned MAX_NIBBLES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  vpw_pkg::reg_idx_t   wr_index,
    input  vpw_pkg::tick_t      wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  vpw_pkg::tick_t      stamp_ticks,
    input  logic [9:0]          ms_stamp,
    output logic                out_valid,
    input  logic                out_stall,
    output vpw_pkg::char_t      out_char,
    output logic                last_of_run
);
    import vpw_pkg::*;

    localparam int unsigned NIB_W = $clog2(MAX_NIBBLES + 1);
    localparam logic [NIB_W-1:0] NIB_LIMIT = NIB_W'(MAX_NIBBLES);

    tick_t short_min_reg, long_min_reg, sof_min_reg, eof_min_reg;

    logic            iv_reg;
    logic            req_reg;
    tick_t           stamp_reg;
    logic [MS_W-1:0] ms_reg;

    tick_t           prev_reg, prev_next;
    logic            level_reg, level_next;
    logic [3:0]      shift_reg, shift_next;
    logic [1:0]      held_reg, held_next;
    logic            armed_reg, armed_next;
    logic [NIB_W-1:0] nib_reg, nib_next;

    char_t     chars_reg [MAX_CHARS];
    char_t     chars_new [MAX_CHARS];
    char_cnt_t cnt_reg, cnt_new;

    logic    advance;
    logic    out_xfer;
    tick_t   width;
    logic    level_t;
    logic    bit_val;
    logic [3:0] shift_t;
    digits_t dig;

    assign out_xfer  = out_valid && !out_stall;
    assign advance   = iv_reg && ((cnt_reg == CNT_NONE) || ((cnt_reg == CNT_ONE) && out_xfer));
    assign in_stall  = iv_reg && !advance;
    assign out_valid = (cnt_reg != CNT_NONE);
    assign out_char  = chars_reg[0];
    assign last_of_run = (cnt_reg == CNT_ONE);

    assign width   = stamp_reg - prev_reg;
    assign level_t = ~level_reg;
    assign bit_val = (width < long_min_reg) ^ level_t;
    assign shift_t = {shift_reg[2:0], bit_val};
    assign dig     = ms_digits(ms_reg);

    // decode of the registered item
    always_comb
    begin
        prev_next  = prev_reg;
        level_next = level_reg;
        shift_next = shift_reg;
        held_next  = held_reg;
        armed_next = armed_reg;
        nib_next   = nib_reg;
        cnt_new    = CNT_NONE;
        for (int i = 0; i < MAX_CHARS; i++)
            chars_new[i] = CHAR_CR;
        if (req_reg)
        begin
            if (armed_reg)
            begin
                shift_next   = 4'd0;
                held_next    = 2'd0;
                armed_next   = 1'b0;
                nib_next     = '0;
                prev_next    = stamp_reg;
                chars_new[0] = CHAR_CR;
                chars_new[1] = CHAR_LF;
                cnt_new      = CNT_EOL;
            end
        end
        else
        begin
            prev_next  = stamp_reg;
            level_next = level_t;
            if (!((width >= eof_min_reg) || (width < short_min_reg)))
            begin
                armed_next = 1'b1;
                if (!level_t && (width >= sof_min_reg))
                begin
                    chars_new[0] = CHAR_ZERO + char_t'(dig.hun);
                    chars_new[1] = CHAR_ZERO + char_t'(dig.ten);
                    chars_new[2] = CHAR_ZERO + char_t'(dig.one);
                    chars_new[3] = CHAR_CR;
                    chars_new[4] = CHAR_LF;
                    chars_new[5] = CHAR_J;
                    cnt_new      = CNT_FRAME;
                    shift_next   = 4'd0;
                    held_next    = 2'd0;
                    nib_next     = '0;
                end
                else if (held_reg != 2'd3)
                begin
                    shift_next = shift_t;
                    held_next  = held_reg + 2'd1;
                end
                else
                begin
                    if (nib_reg < NIB_LIMIT)
                    begin
                        chars_new[0] = (shift_t > 4'd9) ? CHAR_HEX_AF + char_t'(shift_t)
                                                        : CHAR_ZERO + char_t'(shift_t);
                        cnt_new      = CNT_ONE;
                        nib_next     = nib_reg + NIB_W'(1);
                    end
                    shift_next = 4'd0;
                    held_next  = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg   <= SHORT_MIN_RST;
            long_min_reg    <= LONG_MIN_RST;
            sof_min_reg     <= SOF_MIN_RST;
            eof_min_reg     <= EOF_MIN_RST;
            iv_reg          <= 1'b0;
            prev_reg        <= '0;
            level_reg       <= START_LEVEL_RST;
            shift_reg       <= 4'd0;
            held_reg        <= 2'd0;
            armed_reg       <= 1'b0;
            nib_reg         <= '0;
            cnt_reg         <= CNT_NONE;
        end
        else
        begin
            if (in_valid && !in_stall)
                iv_reg <= 1'b1;
            else if (advance)
                iv_reg <= 1'b0;

            if (advance)
            begin
                prev_reg  <= prev_next;
                shift_reg <= shift_next;
                held_reg  <= held_next;
                armed_reg <= armed_next;
                nib_reg   <= nib_next;
            end

            // a start level write loads the line level, ahead of a decode update
            if (wr_en && (wr_index == REG_START_LEVEL))
                level_reg <= wr_data[0];
            else if (advance)
                level_reg <= level_next;

            if (wr_en)
            begin
                unique case (wr_index)
                    REG_SHORT_MIN: short_min_reg <= wr_data;
                    REG_LONG_MIN:  long_min_reg  <= wr_data;
                    REG_SOF_MIN:   sof_min_reg   <= wr_data;
                    REG_EOF_MIN:   eof_min_reg   <= wr_data;
                    default: ;
                endcase
            end

            if (advance && (cnt_new != CNT_NONE))
                cnt_reg <= cnt_new;
            else if (out_xfer)
                cnt_reg <= cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg   <= req_type;
            stamp_reg <= stamp_ticks;
            ms_reg    <= ms_stamp;
        end
        if (advance && (cnt_new != CNT_NONE))
        begin
            for (int i = 0; i < MAX_CHARS; i++)
                chars_reg[i] <= chars_new[i];
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < MAX_CHARS - 1; i++)
                chars_reg[i] <= chars_reg[i+1];
        end
    end

endmodule

// ----- rtl/vpw_checker.sv -----
// ----------------------------------------------------------------------------
// VPW decoder port checker
// Watches the top level's ports for handshake and character stream rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vpw_pulse_width_decoder_macros.svh"

module vpw_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input vpw_pkg::char_t out_char,
    input logic           last_of_run
);
    import vpw_pkg::*;

    `VPW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(last_of_run), "stalled result changed")
    `VPW_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !last_of_run, out_valid, "gap inside a character run")
    `VPW_ASSERT_NOW(a_no_stall_idle, !out_valid, !in_stall, "input stalled with output empty")
    `VPW_ASSERT_NOW(a_cr_not_last, out_valid && (out_char == CHAR_CR), !last_of_run, "CR ended a run")

endmodule

bind vpw_pulse_width_decoder vpw_checker u_vpw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
);
